// ----- rtl/tcma_pkg.sv -----
package tcma_pkg;

    // Field widths of the transactions
    localparam int COORD_W = 32;
    localparam int COT_W   = 32;
    localparam int SHARE_W = 48;

    // Internal datapath widths
    localparam int DIFF_W = COORD_W + 1;     // edge vector component
    localparam int PROD_W = 2 * DIFF_W;      // product of two components
    localparam int DOT_W  = PROD_W + 1;      // sum of three products, signed
    localparam int MAG_W  = PROD_W;          // magnitude of a dot, length or cross term
    localparam int HALF_W = MAG_W / 2;       // split point for the wide products
    localparam int SQ_W   = 2 * MAG_W;       // square / length-times-dot product
    localparam int NUM_W  = SQ_W + 1;        // sum of two such products
    localparam int ROOT_W = SQ_W / 2;        // integer root of the squared cross norm

    localparam logic [SHARE_W-1:0] SHARE_MAX   = '1;
    localparam logic [COT_W-1:0]   COT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COT_W-1:0]   COT_NEG_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        CORNER_FIRST,
        CORNER_SECOND,
        CORNER_THIRD
    } t_corner;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } t_tri;

    typedef struct packed {
        logic signed [COT_W-1:0] cot_first;
        logic signed [COT_W-1:0] cot_second;
        logic signed [COT_W-1:0] cot_third;
        logic [SHARE_W-1:0]      share_first;
        logic [SHARE_W-1:0]      share_second;
        logic [SHARE_W-1:0]      share_third;
        logic                    degenerate;
    } t_res;

endpackage

// ----- rtl/tcma_sqrt.sv -----
module tcma_sqrt #(
    parameter int ROOT_W = 66
) (
    input  logic                  i_clk,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);
    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [2*ROOT_W-1:0] r_rad  [ROOT_W];

    // One root bit per stage: bring down two radicand bits, try 4*root+1
    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0]    w_rem_in;
        logic [ROOT_W-1:0]   w_root_in;
        logic [2*ROOT_W-1:0] w_rad_in;
        logic [REM_W+1:0]    w_try;
        logic [REM_W+1:0]    w_trial;
        logic                w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        assign w_try   = {w_rem_in, w_rad_in[2*ROOT_W-1 -: 2]};
        assign w_trial = (REM_W+2)'({w_root_in, 2'b01});
        assign w_ge    = (w_try >= w_trial);

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= w_ge ? REM_W'(w_try - w_trial) : w_try[REM_W-1:0];
            r_root[s] <= {w_root_in[ROOT_W-2:0], w_ge};
            r_rad[s]  <= w_rad_in << 2;
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ----- rtl/tcma_div.sv -----
module tcma_div #(
    parameter int NUM_W = 82,
    parameter int DEN_W = 66,
    parameter int Q_W   = 48
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf
);
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]   r_low [Q_W+1];
    logic [Q_W-1:0]   r_quo [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic             r_ovf [Q_W+1];

    logic [CMP_W-1:0] w_hi;
    logic             w_ovf0;

    // Flag a quotient that does not fit in Q_W bits (also a zero divisor)
    assign w_hi   = CMP_W'(i_num[NUM_W-1:Q_W]);
    assign w_ovf0 = (w_hi >= CMP_W'(i_den));

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_ovf0 ? '0 : w_hi[DEN_W-1:0];
        r_low[0] <= i_num[Q_W-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_ovf[0] <= w_ovf0;
    end

    // Restoring division, one quotient bit per stage
    for (genvar s = 1; s <= Q_W; s++) begin : g_stage
        logic [DEN_W:0] w_try;
        logic [DEN_W:0] w_den;
        logic           w_ge;

        assign w_try = {r_rem[s-1], r_low[s-1][Q_W-1]};
        assign w_den = {1'b0, r_den[s-1]};
        assign w_ge  = (w_try >= w_den);

        always_ff @(posedge i_clk) begin
            r_rem[s] <= w_ge ? DEN_W'(w_try - w_den) : w_try[DEN_W-1:0];
            r_low[s] <= r_low[s-1] << 1;
            r_quo[s] <= {r_quo[s-1][Q_W-2:0], w_ge};
            r_den[s] <= r_den[s-1];
            r_ovf[s] <= r_ovf[s-1];
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

// ----- rtl/triangle_cotangent_mixed_area.sv -----
// Cotangent weights and mixed-area shares of one triangle. Pulse start with a
// triangle on i_tri; busy never rises, so a new triangle may be given every
// cycle. Each triangle comes back on o_res, marked by a one-cycle o_valid, in
// the order the triangles went in. The path runs through the 66-stage square
// root of the squared cross norm and the 49-stage dividers that follow it.
// There is no output buffering: o_res holds for one cycle only and must be
// captured when o_valid is high.
module triangle_cotangent_mixed_area #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tcma_pkg::t_tri   i_tri,
    output logic             o_valid,
    output tcma_pkg::t_res   o_res
);
    import tcma_pkg::*;

    localparam int DIV_LAT = SHARE_W + 1;
    localparam int LATENCY = 7 + ROOT_W + DIV_LAT + 1;
    localparam int CNUM_W  = MAG_W + COORD_FRAC_BITS;
    localparam int SNUM_W  = NUM_W - COORD_FRAC_BITS - 3;

    typedef struct packed {
        logic                  degen;
        logic [2:0]            dneg;
        logic [2:0]            dzero;
        logic [2:0][MAG_W-1:0] dmag;
    } t_info;

    typedef struct packed {
        t_info                 info;
        logic [2:0][NUM_W-1:0] num;
    } t_mid;

    typedef struct packed {
        logic               degen;
        logic [2:0]         dneg;
        logic [2:0]         dzero;
        logic [2:0]         nzero;
        logic               nonobt;
        t_corner            obt;
        logic [SHARE_W-1:0] quarter;
        logic [SHARE_W-1:0] eighth;
    } t_tail;

    assign busy = 1'b0;

    // Valid bits of the front stages
    logic [7:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:1], start & ~busy};
        end
    end

    // Stage 1: edge vectors
    logic signed [COORD_W-1:0] w_v0 [3];
    logic signed [COORD_W-1:0] w_v1 [3];
    logic signed [COORD_W-1:0] w_v2 [3];
    logic signed [DIFF_W-1:0]  r_a  [3];
    logic signed [DIFF_W-1:0]  r_b  [3];
    logic signed [DIFF_W-1:0]  r_c  [3];
    logic signed [DIFF_W-1:0]  r_na [3];

    always_comb begin
        w_v0[0] = i_tri.first_x;
        w_v0[1] = i_tri.first_y;
        w_v0[2] = i_tri.first_z;
        w_v1[0] = i_tri.second_x;
        w_v1[1] = i_tri.second_y;
        w_v1[2] = i_tri.second_z;
        w_v2[0] = i_tri.third_x;
        w_v2[1] = i_tri.third_y;
        w_v2[2] = i_tri.third_z;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_a[j]  <= $signed({w_v1[j][COORD_W-1], w_v1[j]})
                     - $signed({w_v0[j][COORD_W-1], w_v0[j]});
            r_b[j]  <= $signed({w_v2[j][COORD_W-1], w_v2[j]})
                     - $signed({w_v0[j][COORD_W-1], w_v0[j]});
            r_c[j]  <= $signed({w_v2[j][COORD_W-1], w_v2[j]})
                     - $signed({w_v1[j][COORD_W-1], w_v1[j]});
            r_na[j] <= $signed({w_v0[j][COORD_W-1], w_v0[j]})
                     - $signed({w_v1[j][COORD_W-1], w_v1[j]});
        end
    end

    // Stage 2: component products for lengths, dots and the cross product
    logic signed [PROD_W-1:0] r_lp [3][3];
    logic signed [PROD_W-1:0] r_dp [3][3];
    logic signed [PROD_W-1:0] r_cp [3][2];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_lp[0][j] <= r_c[j] * r_c[j];
            r_lp[1][j] <= r_b[j] * r_b[j];
            r_lp[2][j] <= r_a[j] * r_a[j];
            r_dp[0][j] <= r_a[j] * r_b[j];
            r_dp[1][j] <= r_na[j] * r_c[j];
            r_dp[2][j] <= r_b[j] * r_c[j];
        end
        r_cp[0][0] <= r_a[1] * r_b[2];
        r_cp[0][1] <= r_a[2] * r_b[1];
        r_cp[1][0] <= r_a[2] * r_b[0];
        r_cp[1][1] <= r_a[0] * r_b[2];
        r_cp[2][0] <= r_a[0] * r_b[1];
        r_cp[2][1] <= r_a[1] * r_b[0];
    end

    // Stage 3: sum the products
    logic [MAG_W-1:0]        r3_len [3];
    logic signed [DOT_W-1:0] r3_dot [3];
    logic signed [DOT_W-1:0] r3_crs [3];
    logic signed [DOT_W-1:0] n_lsum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lsum[k] = DOT_W'(r_lp[k][0]) + DOT_W'(r_lp[k][1]) + DOT_W'(r_lp[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_len[k] <= n_lsum[k][MAG_W-1:0];
            r3_dot[k] <= DOT_W'(r_dp[k][0]) + DOT_W'(r_dp[k][1]) + DOT_W'(r_dp[k][2]);
            r3_crs[k] <= DOT_W'(r_cp[k][0]) - DOT_W'(r_cp[k][1]);
        end
    end

    // Stage 4: magnitudes, signs and the degenerate test
    logic [MAG_W-1:0] r4_len  [3];
    logic [MAG_W-1:0] r4_cmag [3];
    t_info            r4_info;

    always_ff @(posedge i_clk) begin
        r4_info.degen <= (r3_len[0] == '0) || (r3_len[1] == '0) || (r3_len[2] == '0);
        for (int k = 0; k < 3; k++) begin
            r4_len[k]        <= r3_len[k];
            r4_cmag[k]       <= r3_crs[k][DOT_W-1] ? MAG_W'(-r3_crs[k]) : MAG_W'(r3_crs[k]);
            r4_info.dneg[k]  <= r3_dot[k][DOT_W-1];
            r4_info.dzero[k] <= (r3_dot[k] == '0);
            r4_info.dmag[k]  <= r3_dot[k][DOT_W-1] ? MAG_W'(-r3_dot[k]) : MAG_W'(r3_dot[k]);
        end
    end

    // Stage 5: half-width partial products of the squares and length terms
    logic [PROD_W-1:0] r5_chh [3];
    logic [PROD_W-1:0] r5_chl [3];
    logic [PROD_W-1:0] r5_cll [3];
    logic [PROD_W-1:0] r5_thh [3];
    logic [PROD_W-1:0] r5_thl [3];
    logic [PROD_W-1:0] r5_tlh [3];
    logic [PROD_W-1:0] r5_tll [3];
    t_info             r5_info;

    always_ff @(posedge i_clk) begin
        r5_info <= r4_info;
        for (int k = 0; k < 3; k++) begin
            r5_chh[k] <= r4_cmag[k][MAG_W-1:HALF_W] * r4_cmag[k][MAG_W-1:HALF_W];
            r5_chl[k] <= r4_cmag[k][MAG_W-1:HALF_W] * r4_cmag[k][HALF_W-1:0];
            r5_cll[k] <= r4_cmag[k][HALF_W-1:0] * r4_cmag[k][HALF_W-1:0];
            r5_thh[k] <= r4_len[k][MAG_W-1:HALF_W] * r4_info.dmag[k][MAG_W-1:HALF_W];
            r5_thl[k] <= r4_len[k][MAG_W-1:HALF_W] * r4_info.dmag[k][HALF_W-1:0];
            r5_tlh[k] <= r4_len[k][HALF_W-1:0] * r4_info.dmag[k][MAG_W-1:HALF_W];
            r5_tll[k] <= r4_len[k][HALF_W-1:0] * r4_info.dmag[k][HALF_W-1:0];
        end
    end

    // Stage 6: combine partial products
    logic [SQ_W-1:0] r6_sq   [3];
    logic [SQ_W-1:0] r6_term [3];
    t_info           r6_info;

    always_ff @(posedge i_clk) begin
        r6_info <= r5_info;
        for (int k = 0; k < 3; k++) begin
            r6_sq[k]   <= (SQ_W'(r5_chh[k]) << (2 * HALF_W))
                        + (SQ_W'(r5_chl[k]) << (HALF_W + 1))
                        + SQ_W'(r5_cll[k]);
            r6_term[k] <= (SQ_W'(r5_thh[k]) << (2 * HALF_W))
                        + ((SQ_W'(r5_thl[k]) + SQ_W'(r5_tlh[k])) << HALF_W)
                        + SQ_W'(r5_tll[k]);
        end
    end

    // Stage 7: squared cross norm and Voronoi numerators
    logic [SQ_W-1:0]  r7_sq;
    logic [NUM_W-1:0] r7_num [3];
    t_info            r7_info;

    always_ff @(posedge i_clk) begin
        r7_info   <= r6_info;
        r7_sq     <= r6_sq[0] + r6_sq[1] + r6_sq[2];
        r7_num[0] <= NUM_W'(r6_term[1]) + NUM_W'(r6_term[2]);
        r7_num[1] <= NUM_W'(r6_term[0]) + NUM_W'(r6_term[2]);
        r7_num[2] <= NUM_W'(r6_term[1]) + NUM_W'(r6_term[0]);
    end

    // Square root of the squared cross norm; side data rides alongside
    logic [ROOT_W-1:0] w_root;
    logic [ROOT_W-1:0] r_mid_vld;
    t_mid              r_mid [ROOT_W];

    tcma_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r7_sq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= '0;
        end else begin
            r_mid_vld <= {r_mid_vld[ROOT_W-2:0], r_vld[7]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid[0].info <= r7_info;
        for (int k = 0; k < 3; k++) begin
            r_mid[0].num[k] <= r7_num[k];
        end
        for (int i = 1; i < ROOT_W; i++) begin
            r_mid[i] <= r_mid[i-1];
        end
    end

    // Divider operands, obtuse corner and the fixed area fractions
    t_mid              w_mid;
    logic [CNUM_W-1:0] w_cnum [3];
    logic [SNUM_W-1:0] w_snum [3];
    logic [ROOT_W-1:0] w_qv;
    logic [ROOT_W-1:0] w_ev;
    t_tail             n_tail;

    assign w_mid = r_mid[ROOT_W-1];
    assign w_qv  = w_root >> (COORD_FRAC_BITS + 2);
    assign w_ev  = w_root >> (COORD_FRAC_BITS + 3);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cnum[k]      = {w_mid.info.dmag[k], {COORD_FRAC_BITS{1'b0}}};
            w_snum[k]      = w_mid.num[k][NUM_W-1:COORD_FRAC_BITS+3];
            n_tail.nzero[k] = (w_mid.num[k] == '0);
        end
        n_tail.degen   = w_mid.info.degen;
        n_tail.dneg    = w_mid.info.dneg;
        n_tail.dzero   = w_mid.info.dzero;
        n_tail.nonobt  = ~|w_mid.info.dneg;
        if (w_mid.info.dneg[0]) begin
            n_tail.obt = CORNER_FIRST;
        end else if (w_mid.info.dneg[1]) begin
            n_tail.obt = CORNER_SECOND;
        end else begin
            n_tail.obt = CORNER_THIRD;
        end
        n_tail.quarter = (|w_qv[ROOT_W-1:SHARE_W]) ? SHARE_MAX : w_qv[SHARE_W-1:0];
        n_tail.eighth  = (|w_ev[ROOT_W-1:SHARE_W]) ? SHARE_MAX : w_ev[SHARE_W-1:0];
    end

    // Cotangent and share dividers, all with the same latency
    logic [SHARE_W-1:0] w_cq  [3];
    logic               w_cov [3];
    logic [SHARE_W-1:0] w_sq  [3];
    logic               w_sov [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        tcma_div #(
            .NUM_W (CNUM_W),
            .DEN_W (ROOT_W),
            .Q_W   (SHARE_W)
        ) u_cot_div (
            .i_clk (i_clk),
            .i_num (w_cnum[k]),
            .i_den (w_root),
            .o_quo (w_cq[k]),
            .o_ovf (w_cov[k])
        );

        tcma_div #(
            .NUM_W (SNUM_W),
            .DEN_W (ROOT_W),
            .Q_W   (SHARE_W)
        ) u_share_div (
            .i_clk (i_clk),
            .i_num (w_snum[k]),
            .i_den (w_root),
            .o_quo (w_sq[k]),
            .o_ovf (w_sov[k])
        );
    end

    logic [DIV_LAT-1:0] r_tail_vld;
    t_tail              r_tail [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_vld <= '0;
        end else begin
            r_tail_vld <= {r_tail_vld[DIV_LAT-2:0], r_mid_vld[ROOT_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail[0] <= n_tail;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_tail[i] <= r_tail[i-1];
        end
    end

    // Saturate, pick the share rule, zero out degenerate triangles
    t_tail              w_tail;
    logic [COT_W-1:0]   n_cot   [3];
    logic [SHARE_W-1:0] n_share [3];
    logic [COT_W-1:0]   n_neg;
    t_res               n_res;
    t_res               r_res;
    logic               r_valid;

    assign w_tail = r_tail[DIV_LAT-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_neg = '0;
            if (w_tail.dzero[k]) begin
                n_cot[k] = '0;
            end else if (!w_tail.dneg[k]) begin
                n_cot[k] = (w_cov[k] || (|w_cq[k][SHARE_W-1:COT_W-1]))
                         ? COT_POS_MAX : w_cq[k][COT_W-1:0];
            end else begin
                n_neg    = (w_cov[k] || (|w_cq[k][SHARE_W-1:COT_W])
                            || (w_cq[k][COT_W-1] && (|w_cq[k][COT_W-2:0])))
                         ? COT_NEG_MAX : w_cq[k][COT_W-1:0];
                n_cot[k] = '0 - n_neg;
            end

            if (w_tail.nonobt) begin
                if (w_tail.nzero[k]) begin
                    n_share[k] = '0;
                end else if (w_sov[k]) begin
                    n_share[k] = SHARE_MAX;
                end else begin
                    n_share[k] = w_sq[k];
                end
            end else if (2'(k) == w_tail.obt) begin
                n_share[k] = w_tail.quarter;
            end else begin
                n_share[k] = w_tail.eighth;
            end

            if (w_tail.degen) begin
                n_cot[k]   = '0;
                n_share[k] = '0;
            end
        end
        n_res.cot_first    = n_cot[0];
        n_res.cot_second   = n_cot[1];
        n_res.cot_third    = n_cot[2];
        n_res.share_first  = n_share[0];
        n_res.share_second = n_share[1];
        n_res.share_third  = n_share[2];
        n_res.degenerate   = w_tail.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_tail_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTH
    // Every accepted triangle comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result missing after fixed latency");

    // A degenerate triangle reports all-zero cotangents and shares
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.degenerate) |->
            (o_res.cot_first == '0 && o_res.cot_second == '0 && o_res.cot_third == '0
             && o_res.share_first == '0 && o_res.share_second == '0
             && o_res.share_third == '0))
        else $error("degenerate result carries nonzero data");

    // Reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
`endif

endmodule

// ----- verif/tb_triangle_cotangent_mixed_area.sv -----
module tb_triangle_cotangent_mixed_area;
    timeunit 1ns;
    timeprecision 1ps;

    import tcma_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = 123;
    localparam int N_RANDOM  = 200;
    localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_tri   i_tri;
    logic   o_valid;
    t_res   o_res;

    t_res   expected_q[$];
    int     n_errors;
    int     idle_pct;

    triangle_cotangent_mixed_area #(.COORD_FRAC_BITS(FRAC)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_tri   (i_tri),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // Generate the clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Integer square root, floor
    function automatic logic [255:0] root_floor(logic [255:0] x);
        logic [255:0] r;
        logic [255:0] t;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            t = r | (256'd1 << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Cotangent from dot product and twice the area, saturated
    function automatic logic [COT_W-1:0] cot_of(logic signed [255:0] dot,
                                                 logic signed [255:0] n);
        logic signed [255:0] mag;
        logic signed [255:0] q;
        if (dot == 0) return '0;
        if (n == 0) return (dot < 0) ? COT_NEG_MAX : COT_POS_MAX;
        mag = (dot < 0) ? -dot : dot;
        q   = (mag <<< FRAC) / n;
        if (dot >= 0) return (q > 256'sh7FFF_FFFF) ? COT_POS_MAX : q[COT_W-1:0];
        if (q > 256'sh8000_0000) q = 256'sh8000_0000;
        return -q[COT_W-1:0];
    endfunction

    function automatic logic [SHARE_W-1:0] sat_share(logic signed [255:0] v);
        return (v > $signed({208'd0, SHARE_MAX})) ? SHARE_MAX : v[SHARE_W-1:0];
    endfunction

    // Non-obtuse Voronoi share
    function automatic logic [SHARE_W-1:0] voronoi(logic signed [255:0] num,
                                                   logic signed [255:0] den);
        if (den == 0) return (num == 0) ? '0 : SHARE_MAX;
        return sat_share(num / den);
    endfunction

    // Predict cotangents and mixed-area shares of one triangle
    function automatic t_res triangle_weights(t_tri t);
        t_res                r;
        logic signed [255:0] v0[3], v1[3], v2[3], a[3], b[3], c[3];
        logic signed [255:0] len[3], dot[3];
        logic signed [255:0] cx, cy, cz, n, den;
        logic [255:0]        sq;
        t_corner             obt;
        v0 = '{t.first_x, t.first_y, t.first_z};
        v1 = '{t.second_x, t.second_y, t.second_z};
        v2 = '{t.third_x, t.third_y, t.third_z};
        for (int j = 0; j < 3; j++) begin
            a[j] = v1[j] - v0[j];
            b[j] = v2[j] - v0[j];
            c[j] = v2[j] - v1[j];
        end
        r = '0;
        len[0] = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
        len[1] = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
        len[2] = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        if (len[0] == 0 || len[1] == 0 || len[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        dot[0] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        dot[1] = -(a[0]*c[0] + a[1]*c[1] + a[2]*c[2]);
        dot[2] = b[0]*c[0] + b[1]*c[1] + b[2]*c[2];
        cx = a[1]*b[2] - a[2]*b[1];
        cy = a[2]*b[0] - a[0]*b[2];
        cz = a[0]*b[1] - a[1]*b[0];
        sq = cx*cx + cy*cy + cz*cz;
        n  = root_floor(sq);
        r.cot_first  = cot_of(dot[0], n);
        r.cot_second = cot_of(dot[1], n);
        r.cot_third  = cot_of(dot[2], n);
        if (dot[0] >= 0 && dot[1] >= 0 && dot[2] >= 0) begin
            den = n <<< (FRAC + 3);
            r.share_first  = voronoi(len[1]*dot[1] + len[2]*dot[2], den);
            r.share_second = voronoi(len[0]*dot[0] + len[2]*dot[2], den);
            r.share_third  = voronoi(len[1]*dot[1] + len[0]*dot[0], den);
        end else begin
            obt = (dot[0] < 0) ? CORNER_FIRST : ((dot[1] < 0) ? CORNER_SECOND : CORNER_THIRD);
            r.share_first  = sat_share(n >>> (FRAC + 3));
            r.share_second = r.share_first;
            r.share_third  = r.share_first;
            case (obt)
                CORNER_FIRST:  r.share_first  = sat_share(n >>> (FRAC + 2));
                CORNER_SECOND: r.share_second = sat_share(n >>> (FRAC + 2));
                default:       r.share_third  = sat_share(n >>> (FRAC + 2));
            endcase
        end
        return r;
    endfunction

    // Record the prediction for each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) expected_q = {expected_q, triangle_weights(i_tri)};
    end

    // Compare each result against the oldest prediction
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result %h", $time, o_res);
            end else begin
                e = expected_q.pop_front();
                if (o_res.cot_first !== e.cot_first) begin
                    n_errors++;
                    $display("%0t: cot_first exp %h got %h", $time, e.cot_first, o_res.cot_first);
                end
                if (o_res.cot_second !== e.cot_second) begin
                    n_errors++;
                    $display("%0t: cot_second exp %h got %h", $time, e.cot_second,
                             o_res.cot_second);
                end
                if (o_res.cot_third !== e.cot_third) begin
                    n_errors++;
                    $display("%0t: cot_third exp %h got %h", $time, e.cot_third, o_res.cot_third);
                end
                if (o_res.share_first !== e.share_first) begin
                    n_errors++;
                    $display("%0t: share_first exp %h got %h", $time, e.share_first,
                             o_res.share_first);
                end
                if (o_res.share_second !== e.share_second) begin
                    n_errors++;
                    $display("%0t: share_second exp %h got %h", $time, e.share_second,
                             o_res.share_second);
                end
                if (o_res.share_third !== e.share_third) begin
                    n_errors++;
                    $display("%0t: share_third exp %h got %h", $time, e.share_third,
                             o_res.share_third);
                end
                if (o_res.degenerate !== e.degenerate) begin
                    n_errors++;
                    $display("%0t: degenerate exp %b got %b", $time, e.degenerate,
                             o_res.degenerate);
                end
            end
        end
    end

    // Send one triangle; hold start high until the transaction is taken
    task automatic send_triangle(t_tri t);
        start <= 1'b1;
        i_tri <= t;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_tri <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom};
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
    endtask

    function automatic t_tri make_tri(logic signed [31:0] x0, y0, z0, x1, y1, z1,
                                      x2, y2, z2);
        t_tri t;
        t = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
        return t;
    endfunction

    // Drop start and hold until every result is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, every angle class and the degenerate cases
    task automatic test_directed();
        send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_triangle(make_tri(0, 0, 0, 2*ONE, 0, 0, -2*ONE, ONE, 0));
        send_triangle(make_tri(2*ONE, 0, 0, 0, 0, 0, -2*ONE, ONE, 0));
        send_triangle(make_tri(2*ONE, 0, 0, -2*ONE, ONE, 0, 0, 0, 0));
        send_triangle(make_tri(0, 0, 0, 2*ONE, 0, 0, ONE, 2*ONE, 0));
        send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 3*ONE, 0, 0));
        send_triangle(make_tri(ONE, 0, 0, 0, 0, 0, 3*ONE, 0, 0));
        send_triangle(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, 0, 0));
        send_triangle(make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, 0));
        send_triangle(make_tri(C_MAX, C_MIN, 0, C_MIN, C_MAX, 0, C_MAX, C_MAX, C_MAX));
        send_triangle(make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN));
        send_triangle(make_tri(C_MIN, 0, 0, C_MAX, 0, 0, 0, 1, 0));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(make_tri(0, 0, 0, C_MAX, 0, 0, C_MAX, 1, 0));
        send_triangle(make_tri(0, 0, 0, 3, 0, 0, 1, 1, 0));
        send_triangle(make_tri(-1, -1, -1, C_MAX, C_MAX, C_MAX, C_MIN, 0, C_MAX));
        send_triangle(make_tri(0, 0, 0, ONE, ONE, 0, ONE, ONE, ONE));
        drain_results();
    endtask

    function automatic logic signed [31:0] rnd_small();
        return $signed($urandom_range(65535)) - 32768;
    endfunction

    // Random triangle: full range, small, collinear, coincident or right-angled
    function automatic t_tri random_triangle();
        t_tri t;
        logic signed [31:0] dx, dy, dz;
        int k;
        k = $urandom_range(99);
        if (k < 35) begin
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end else if (k < 75) begin
            t = make_tri(rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small(),
                         rnd_small(), rnd_small(), rnd_small(), rnd_small());
        end else if (k < 85) begin
            dx = rnd_small();
            dy = rnd_small();
            dz = rnd_small();
            k  = $urandom_range(5) - 2;
            t  = make_tri(rnd_small(), rnd_small(), rnd_small(), 0, 0, 0, 0, 0, 0);
            t.second_x = t.first_x + dx;
            t.second_y = t.first_y + dy;
            t.second_z = t.first_z + dz;
            t.third_x  = t.first_x + k * dx;
            t.third_y  = t.first_y + k * dy;
            t.third_z  = t.first_z + k * dz;
        end else if (k < 92) begin
            t = make_tri(rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small(),
                         rnd_small(), rnd_small(), rnd_small(), rnd_small());
            case ($urandom_range(2))
                0:       {t.second_x, t.second_y, t.second_z} = {t.first_x, t.first_y, t.first_z};
                1:       {t.third_x, t.third_y, t.third_z} = {t.first_x, t.first_y, t.first_z};
                default: {t.third_x, t.third_y, t.third_z} =
                             {t.second_x, t.second_y, t.second_z};
            endcase
        end else begin
            dx = rnd_small();
            dy = rnd_small();
            t  = make_tri(0, 0, rnd_small(), dx, dy, 0, -dy, dx, 0);
            t.second_z = t.first_z;
            t.third_z  = t.first_z;
        end
        return t;
    endfunction

    task automatic test_random(int pct);
        idle_pct = pct;
        for (int i = 0; i < N_RANDOM; i++) send_triangle(random_triangle());
        idle_pct = 0;
    endtask

    // Stop the run if it hangs
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        n_errors = 0;
        idle_pct = 0;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_tri    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(13);
        drain_results();
        test_random(73);
        test_random(0);
        start <= 1'b0;

        // Wait out the pipeline
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
